FILE: design/dual_sound_fifo_trace_engine_assert.svh
// Assertion macros used by the checker module of the sound FIFO engine.
// Both macros sample on the rising edge of clk and are quiet while arst_n is low.
`ifndef DUAL_SOUND_FIFO_TRACE_ENGINE_ASSERT_SVH
`define DUAL_SOUND_FIFO_TRACE_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dsf assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define DSF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dsf assertion failed: next-cycle implication");

`endif

FILE: design/dsf_pkg.sv
package dsf_pkg;

	localparam int FIFO_BYTES = 32;
	localparam logic [31:0] IO_BASE = 32'h0400_0000;

	localparam int PTR_W = $clog2(FIFO_BYTES);
	localparam int CNT_W = $clog2(FIFO_BYTES + 1);

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_REQUEST = 2'd1,
		OP_TICK    = 2'd2,
		OP_BAD     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_ORDER    = 3'd2,
		ST_WIDTH    = 3'd3,
		ST_ADDRESS  = 3'd4,
		ST_OVERFLOW = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ORD_HI,
		S_ORD_LO,
		S_ORD_SEQ,
		S_EXEC,
		S_PUSH,
		S_POP,
		S_DONE
	} state_t;

	// Result of the shared 32-bit magnitude compare.
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

	// Advance a ring pointer with wrap at the end of the ring.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(FIFO_BYTES - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

FILE: design/dual_sound_fifo_trace_engine.sv
// Start runs S_ORD_HI, S_ORD_LO, S_ORD_SEQ, S_EXEC and S_DONE, where done pulses; a FIFO
// push adds S_PUSH (one ring byte per cycle), a timer pop adds S_POP; an out-of-order event
// skips S_EXEC. One event at a time, paced by the three-pass order compare on one shared
// 32-bit comparator, the single write port of each ring and the registered ring read. Reset:
// arst_n clears pointers, counts, holds, timer selects and the order history; ring contents
// stay undefined and are only read after being written. Results cannot be stalled.
module dual_sound_fifo_trace_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic [63:0]        event_cycle,
	input  logic [31:0]        event_sequence,
	input  logic [31:0]        bus_address,
	input  logic [7:0]         access_width,
	input  logic [31:0]        write_value,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [7:0]  held_sample_a,
	output logic signed [7:0]  held_sample_b,
	output logic [5:0]         fill_a,
	output logic [5:0]         fill_b
);
	import dsf_pkg::*;

	// Audio register offsets that accept a halfword write with no visible effect.
	localparam int N_PLAIN = 13;
	localparam logic [31:0] PLAIN_REGS [N_PLAIN] = '{
		32'h60, 32'h62, 32'h64, 32'h68, 32'h6C,
		32'h70, 32'h72, 32'h74, 32'h78, 32'h7C,
		32'h80, 32'h84, 32'h88
	};
	localparam logic [31:0] OFF_CTRL   = 32'h82;
	localparam logic [31:0] OFF_WAVE   = 32'h90;
	localparam logic [31:0] OFF_FIFO_A = 32'hA0;
	localparam logic [31:0] OFF_FIFO_B = 32'hA4;
	localparam int CTRL_SEL_A = 10;
	localparam int CTRL_CLR_A = 11;
	localparam int CTRL_SEL_B = 14;
	localparam int CTRL_CLR_B = 15;

	// Sequencer
	state_t state_q, state_d;

	// Event captured at the start transfer
	op_t         op_q;
	logic [63:0] cyc_q;
	logic [31:0] seq_q;
	logic [31:0] addr_q;
	logic [7:0]  width_q;
	logic [31:0] val_q;

	// Order history and partial compare results
	logic [63:0] last_cyc_q;
	logic [31:0] last_seq_q;
	logic        seen_q;
	logic        lt_hi_q, eq_hi_q, lt_lo_q, eq_lo_q;

	// FIFO state
	logic [7:0]       ring_a [FIFO_BYTES];
	logic [7:0]       ring_b [FIFO_BYTES];
	logic [PTR_W-1:0] rd_a_q, wr_a_q, rd_b_q, wr_b_q;
	logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
	logic [7:0]       hold_a_q, hold_b_q;
	logic [7:0]       rdata_a_q, rdata_b_q;
	logic             sel_a_q, sel_b_q;

	// Work in flight
	status_t     status_q;
	logic [1:0]  byte_q;
	logic        push_b_q;
	logic        pop_a_q, pop_b_q;

	// Shared comparator
	logic [31:0] cmp_a, cmp_b;
	cmp_res_t    cmp_res;
	logic        order_fail;

	// Execute-step decode
	status_t     exec_status;
	logic        exec_push, exec_push_b, exec_ctrl, exec_tick;
	logic        exec_pop_a, exec_pop_b;
	logic [31:0] off;
	logic        below_base, plain_hit;
	logic [8:0]  wave_end;
	logic [7:0]  push_byte;

	dsf_cmp u_cmp (
		.a   (cmp_a),
		.b   (cmp_b),
		.res (cmp_res)
	);

	// Route the shared comparator: high stamp word, low stamp word, then sequence.
	always_comb begin
		unique case (state_q)
			S_ORD_HI: begin
				cmp_a = cyc_q[63:32];
				cmp_b = last_cyc_q[63:32];
			end
			S_ORD_LO: begin
				cmp_a = cyc_q[31:0];
				cmp_b = last_cyc_q[31:0];
			end
			default: begin
				cmp_a = seq_q;
				cmp_b = last_seq_q;
			end
		endcase
	end

	// Refuse an event that is not strictly after the last accepted one.
	assign order_fail = seen_q && (lt_hi_q || (eq_hi_q && (lt_lo_q ||
		(eq_lo_q && (cmp_res.lt || cmp_res.eq)))));

	// Decode the captured event into a status and its side effects.
	always_comb begin
		off         = addr_q - IO_BASE;
		below_base  = (addr_q < IO_BASE);
		wave_end    = {1'b0, off[7:0]} + {1'b0, width_q};
		plain_hit   = 1'b0;
		for (int i = 0; i < N_PLAIN; i++) begin
			if (off == PLAIN_REGS[i]) begin
				plain_hit = 1'b1;
			end
		end
		exec_status = ST_OK;
		exec_push   = 1'b0;
		exec_push_b = 1'b0;
		exec_ctrl   = 1'b0;
		exec_tick   = 1'b0;
		unique case (op_q)
			OP_WRITE: begin
				priority if (!below_base && off >= OFF_WAVE && off < OFF_FIFO_A) begin
					if (width_q != 8'd1 && width_q != 8'd2 && width_q != 8'd4) begin
						exec_status = ST_WIDTH;
					end else if (wave_end > OFF_FIFO_A[8:0]) begin
						exec_status = ST_ADDRESS;
					end
				end else if (!below_base && (off == OFF_FIFO_A || off == OFF_FIFO_B)) begin
					exec_push_b = (off == OFF_FIFO_B);
					if (width_q != 8'd4) begin
						exec_status = ST_WIDTH;
					end else if ((exec_push_b ? cnt_b_q : cnt_a_q) >
						CNT_W'(FIFO_BYTES - 4)) begin
						exec_status = ST_OVERFLOW;
					end else begin
						exec_push = 1'b1;
					end
				end else if (width_q != 8'd2) begin
					exec_status = ST_WIDTH;
				end else if (below_base) begin
					exec_status = ST_ADDRESS;
				end else if (off == OFF_CTRL) begin
					exec_ctrl = 1'b1;
				end else if (!plain_hit) begin
					exec_status = ST_ADDRESS;
				end
			end
			OP_REQUEST: begin
				if (width_q != '0 || addr_q != '0 || val_q != '0) begin
					exec_status = ST_INVALID;
				end
			end
			OP_TICK: begin
				if (width_q != '0 || addr_q != '0 || val_q[31:1] != '0) begin
					exec_status = ST_INVALID;
				end else begin
					exec_tick = 1'b1;
				end
			end
			OP_BAD: begin
				exec_status = ST_INVALID;
			end
		endcase
		// An empty FIFO keeps its hold on a tick.
		exec_pop_a = exec_tick && (sel_a_q == val_q[0]) && (cnt_a_q != '0);
		exec_pop_b = exec_tick && (sel_b_q == val_q[0]) && (cnt_b_q != '0);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (start) state_d = S_ORD_HI;
			S_ORD_HI:  state_d = S_ORD_LO;
			S_ORD_LO:  state_d = S_ORD_SEQ;
			S_ORD_SEQ: state_d = order_fail ? S_DONE : S_EXEC;
			S_EXEC: begin
				priority if (exec_push) begin
					state_d = S_PUSH;
				end else if (exec_pop_a || exec_pop_b) begin
					state_d = S_POP;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PUSH:    if (byte_q == 2'd3) state_d = S_DONE;
			S_POP:     state_d = S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the event on the start transfer; hold it while busy.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q    <= op_t'(operation);
			cyc_q   <= event_cycle;
			seq_q   <= event_sequence;
			addr_q  <= bus_address;
			width_q <= access_width;
			val_q   <= write_value;
		end
	end

	// Rings: one byte write per cycle, registered read at the read pointer.
	assign push_byte = val_q[{byte_q, 3'b000} +: 8];

	always_ff @(posedge clk) begin
		if (state_q == S_PUSH) begin
			if (push_b_q) begin
				ring_b[wr_b_q] <= push_byte;
			end else begin
				ring_a[wr_a_q] <= push_byte;
			end
		end
		rdata_a_q <= ring_a[rd_a_q];
		rdata_b_q <= ring_b[rd_b_q];
	end

	// Control state and FIFO bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cyc_q <= '0;
			last_seq_q <= '0;
			seen_q     <= 1'b0;
			lt_hi_q    <= 1'b0;
			eq_hi_q    <= 1'b0;
			lt_lo_q    <= 1'b0;
			eq_lo_q    <= 1'b0;
			rd_a_q     <= '0;
			wr_a_q     <= '0;
			cnt_a_q    <= '0;
			hold_a_q   <= '0;
			rd_b_q     <= '0;
			wr_b_q     <= '0;
			cnt_b_q    <= '0;
			hold_b_q   <= '0;
			sel_a_q    <= 1'b0;
			sel_b_q    <= 1'b0;
			status_q   <= ST_OK;
			byte_q     <= '0;
			push_b_q   <= 1'b0;
			pop_a_q    <= 1'b0;
			pop_b_q    <= 1'b0;
		end else begin
			unique case (state_q)
				S_ORD_HI: begin
					lt_hi_q <= cmp_res.lt;
					eq_hi_q <= cmp_res.eq;
				end
				S_ORD_LO: begin
					lt_lo_q <= cmp_res.lt;
					eq_lo_q <= cmp_res.eq;
				end
				S_ORD_SEQ: begin
					if (order_fail) begin
						status_q <= ST_ORDER;
					end
				end
				S_EXEC: begin
					status_q <= exec_status;
					byte_q   <= '0;
					push_b_q <= exec_push_b;
					pop_a_q  <= exec_pop_a;
					pop_b_q  <= exec_pop_b;
					if (exec_status == ST_OK) begin
						last_cyc_q <= cyc_q;
						last_seq_q <= seq_q;
						seen_q     <= 1'b1;
					end
					if (exec_ctrl) begin
						sel_a_q <= val_q[CTRL_SEL_A];
						sel_b_q <= val_q[CTRL_SEL_B];
						// Drop everything held in a cleared FIFO, hold included.
						if (val_q[CTRL_CLR_A]) begin
							rd_a_q   <= '0;
							wr_a_q   <= '0;
							cnt_a_q  <= '0;
							hold_a_q <= '0;
						end
						if (val_q[CTRL_CLR_B]) begin
							rd_b_q   <= '0;
							wr_b_q   <= '0;
							cnt_b_q  <= '0;
							hold_b_q <= '0;
						end
					end
				end
				S_PUSH: begin
					byte_q <= byte_q + 2'd1;
					if (push_b_q) begin
						wr_b_q  <= ptr_next(wr_b_q);
						cnt_b_q <= cnt_b_q + CNT_W'(1);
					end else begin
						wr_a_q  <= ptr_next(wr_a_q);
						cnt_a_q <= cnt_a_q + CNT_W'(1);
					end
				end
				S_POP: begin
					if (pop_a_q) begin
						hold_a_q <= rdata_a_q;
						rd_a_q   <= ptr_next(rd_a_q);
						cnt_a_q  <= cnt_a_q - CNT_W'(1);
					end
					if (pop_b_q) begin
						hold_b_q <= rdata_b_q;
						rd_b_q   <= ptr_next(rd_b_q);
						cnt_b_q  <= cnt_b_q - CNT_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_DONE);
	assign status        = status_q;
	assign held_sample_a = $signed(hold_a_q);
	assign held_sample_b = $signed(hold_b_q);
	assign fill_a        = 6'(cnt_a_q);
	assign fill_b        = 6'(cnt_b_q);

endmodule

FILE: design/dsf_cmp.sv
module dsf_cmp (
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output dsf_pkg::cmp_res_t res
);
	import dsf_pkg::*;

	always_comb begin
		res.lt = (a < b);
		res.eq = (a == b);
	end

endmodule

FILE: design/dsf_checker.sv
`include "dual_sound_fifo_trace_engine_assert.svh"

module dsf_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [2:0]         status,
	input logic [5:0]         fill_a,
	input logic [5:0]         fill_b
);
	import dsf_pkg::*;

	// A result shows for one cycle only, while the block still holds the event.
	`DSF_ASSERT_NXT(a_done_pulse, done, !done)
	`DSF_ASSERT_IMP(a_done_busy, done, busy)
	// A start transfer takes the block busy.
	`DSF_ASSERT_NXT(a_start_busy, start && !busy, busy)
	// At done, reported fill does not exceed the ring, and status is a defined code.
	`DSF_ASSERT_IMP(a_fill_range, done, fill_a <= 6'(FIFO_BYTES) && fill_b <= 6'(FIFO_BYTES))
	`DSF_ASSERT_IMP(a_status_code, done, status <= ST_OVERFLOW)

endmodule

bind dual_sound_fifo_trace_engine dsf_checker u_dsf_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.status (status),
	.fill_a (fill_a),
	.fill_b (fill_b)
);
